FILE: design/whitespace_trim_stream_defines.svh
// Assertion macros shared by the whitespace trimmer modules.
// Defining ASSERT_OFF turns every check into empty text.
`ifndef WHITESPACE_TRIM_STREAM_DEFINES_SVH
`define WHITESPACE_TRIM_STREAM_DEFINES_SVH
`ifndef ASSERT_OFF
`define WTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define WTS_ASSERT(label, clk, rst_n, prop, msg)
`define WTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: design/wts_pkg.sv
// Types, constants and codes of the whitespace trimmer.
// Used by the front, queue, back and top modules; depends on nothing.
`timescale 1ns / 1ps

package wts_pkg;

    localparam int RUN_DEPTH = 32;
    localparam int ADDR_W    = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
    localparam int CNT_W     = $clog2(RUN_DEPTH + 1);

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TRIM_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_CHAR = 2'd1;

    localparam logic [2:0] TRIM_MODE_RESET = 3'd3;
    localparam logic [7:0] KEEP_CHAR_RESET = 8'd0;

    localparam logic [7:0] WHITE_MAX = 8'd32;
    localparam logic [7:0] TEXT_MIN  = 8'd128;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
        logic       run_overflow;
    } out_item_t;

    // One command: replay flush_n held bytes, then optionally one byte.
    typedef struct packed {
        logic [CNT_W-1:0] flush_n;
        logic             emit_byte;
        logic [7:0]       data;
        logic             last;
        logic             overflow;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RD,
        B_WR,
        B_EMIT
    } back_state_t;

endpackage

FILE: design/wts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the white run of the trimmer.
`timescale 1ns / 1ps

module wts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/wts_front.sv
// Front end: configuration registers, byte classification and run bookkeeping.
// Depends on wts_pkg; feeds commands to wts_queue and bytes to wts_ram.
`timescale 1ns / 1ps
`include "whitespace_trim_stream_defines.svh"

module wts_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [wts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  wts_pkg::in_item_t            in_data,
    input  logic                         q_full,
    output logic                         q_push,
    output wts_pkg::cmd_t                q_data,
    input  logic                         flush_done,
    output logic                         ram_we,
    output logic [wts_pkg::ADDR_W-1:0]   ram_waddr,
    output logic [7:0]                   ram_wdata
);

    import wts_pkg::*;

    logic [2:0]       trim_mode_reg;
    logic [7:0]       keep_char_reg;
    logic             seen_reg, seen_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             flush_busy_reg, flush_busy_next;

    logic             lt, rt, ct;
    logic             kept, white, drop_now, keep_now;
    logic             store_wr, step_ovf, push_need, accept;
    logic [CNT_W-1:0] count_after;
    cmd_t             cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_mode_reg <= TRIM_MODE_RESET;
            keep_char_reg <= KEEP_CHAR_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TRIM_MODE: trim_mode_reg <= cfg_data[2:0];
                REG_KEEP_CHAR: keep_char_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign lt = trim_mode_reg[0];
    assign rt = trim_mode_reg[1];
    assign ct = trim_mode_reg[2];

    assign kept  = (keep_char_reg != 8'd0) && (in_data.in_byte == keep_char_reg);
    assign white = ((in_data.in_byte <= WHITE_MAX) || (in_data.in_byte >= TEXT_MIN)) && !kept;
    assign drop_now = seen_reg ? (ct && rt) : lt;
    assign keep_now = seen_reg ? (!ct && !rt) : (!lt && !rt);

    always_comb
    begin
        cmd         = '0;
        store_wr    = 1'b0;
        step_ovf    = 1'b0;
        count_after = count_reg;
        if (!white)
        begin
            if ((count_reg != '0) && (seen_reg ? !ct : !lt))
            begin
                cmd.flush_n = count_reg;
            end
            count_after   = '0;
            cmd.emit_byte = 1'b1;
            cmd.data      = in_data.in_byte;
        end
        else
        begin
            if (!drop_now)
            begin
                if (keep_now && (count_reg == '0))
                begin
                    cmd.emit_byte = 1'b1;
                    cmd.data      = in_data.in_byte;
                end
                else if (count_reg < CNT_W'(RUN_DEPTH))
                begin
                    store_wr    = 1'b1;
                    count_after = count_reg + CNT_W'(1);
                end
                else
                begin
                    step_ovf = 1'b1;
                end
            end
            // At the end of the string the held run is settled.
            if (in_data.in_last && (count_after != '0))
            begin
                if (seen_reg)
                begin
                    cmd.flush_n = rt ? '0 : count_after;
                end
                else if (!lt)
                begin
                    cmd.flush_n = rt ? CNT_W'(1) : count_after;
                end
            end
        end
        cmd.last     = in_data.in_last;
        cmd.overflow = ovf_reg | step_ovf;
        push_need    = (cmd.flush_n != '0) || cmd.emit_byte || in_data.in_last;
    end

    // A pending replay reads the run store, so no new byte may enter until it is done.
    assign in_stall  = q_full || flush_busy_reg;
    assign accept    = in_valid && !in_stall;
    assign q_push    = accept && push_need;
    assign q_data    = cmd;
    assign ram_we    = accept && store_wr;
    assign ram_waddr = count_reg[ADDR_W-1:0];
    assign ram_wdata = in_data.in_byte;

    always_comb
    begin
        seen_next       = seen_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        flush_busy_next = flush_busy_reg;
        if (flush_done)
        begin
            flush_busy_next = 1'b0;
        end
        if (accept)
        begin
            if (q_push && (cmd.flush_n != '0))
            begin
                flush_busy_next = 1'b1;
            end
            if (in_data.in_last)
            begin
                seen_next  = 1'b0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                seen_next  = seen_reg | !white;
                count_next = count_after;
                ovf_next   = ovf_reg | step_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            flush_busy_reg <= 1'b0;
        end
        else
        begin
            seen_reg       <= seen_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            flush_busy_reg <= flush_busy_next;
        end
    end

    `WTS_ASSERT(a_no_store_write_in_flush, clk, rst_n, ram_we |-> !flush_busy_reg, "run store written during replay")
    `WTS_ASSERT_NEXT(a_flush_marks_busy, clk, rst_n, (q_push && (q_data.flush_n != '0)), flush_busy_reg, "replay not tracked")

endmodule

FILE: design/wts_queue.sv
// Short command queue between the front and back ends.
// Depends on wts_pkg for the command type and depth.
`timescale 1ns / 1ps
`include "whitespace_trim_stream_defines.svh"

module wts_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wts_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output wts_pkg::cmd_t head,
    output logic          empty
);

    import wts_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `WTS_ASSERT(a_no_push_when_full, clk, rst_n, push |-> !full, "command queue overrun")
    `WTS_ASSERT(a_no_pop_when_empty, clk, rst_n, pop |-> !empty, "command queue underrun")

endmodule

FILE: design/wts_back.sv
// Back end: carries out queued commands, replaying held runs from the run store.
// Depends on wts_pkg; reads wts_ram and drives the output register.
`timescale 1ns / 1ps
`include "whitespace_trim_stream_defines.svh"

module wts_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  wts_pkg::cmd_t              q_head,
    output logic                       q_pop,
    output logic                       ram_re,
    output logic [wts_pkg::ADDR_W-1:0] ram_raddr,
    input  logic [7:0]                 ram_rdata,
    output logic                       flush_done,
    output logic                       out_valid,
    input  logic                       out_stall,
    output wts_pkg::out_item_t         out_data
);

    import wts_pkg::*;

    back_state_t      state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;
    logic             can_load;
    logic [CNT_W-1:0] idx_inc;

    assign can_load = !out_valid_reg || !out_stall;
    assign idx_inc  = idx_reg + CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg[ADDR_W-1:0];
        flush_done     = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    idx_next   = '0;
                    state_next = (q_head.flush_n != '0) ? B_RD : B_EMIT;
                end
            end
            B_RD:
            begin
                ram_re     = 1'b1;
                state_next = B_WR;
            end
            B_WR:
            begin
                if (can_load)
                begin
                    out_valid_next        = 1'b1;
                    out_next.out_byte     = ram_rdata;
                    out_next.has_byte     = 1'b1;
                    out_next.out_last     = cmd_reg.last && !cmd_reg.emit_byte &&
                                            (idx_inc == cmd_reg.flush_n);
                    out_next.run_overflow = cmd_reg.overflow;
                    idx_next              = idx_inc;
                    if (idx_inc == cmd_reg.flush_n)
                    begin
                        flush_done = 1'b1;
                        state_next = cmd_reg.emit_byte ? B_EMIT : B_IDLE;
                    end
                    else
                    begin
                        state_next = B_RD;
                    end
                end
            end
            B_EMIT:
            begin
                if (can_load)
                begin
                    // A command with no byte here is the bare end marker.
                    out_valid_next        = 1'b1;
                    out_next.out_byte     = cmd_reg.data;
                    out_next.has_byte     = cmd_reg.emit_byte;
                    out_next.out_last     = cmd_reg.last;
                    out_next.run_overflow = cmd_reg.overflow;
                    state_next            = B_IDLE;
                    if (!q_empty)
                    begin
                        q_pop      = 1'b1;
                        cmd_next   = q_head;
                        idx_next   = '0;
                        state_next = (q_head.flush_n != '0) ? B_RD : B_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `WTS_ASSERT(a_replay_in_range, clk, rst_n, (state_reg == B_RD) |-> (idx_reg < cmd_reg.flush_n), "replay index past held run")

endmodule

FILE: design/whitespace_trim_stream.sv
// Whitespace trimmer. A plain byte is queued at its input transfer, passes through the
// back end's command register into the output register; such bytes stream at one a cycle
// while the output is not stalled. A held run of n white bytes is replayed from the run store
// byte by byte (each read, then loaded), and new input waits while a replay is pending.
// Reset is asynchronous and active low: trim_mode returns to 3, keep_char to 0, the
// queue empties and the run store keeps its contents, which are only read once written.
`timescale 1ns / 1ps

module whitespace_trim_stream (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  wts_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output wts_pkg::out_item_t            out_data
);

    import wts_pkg::*;

    logic              q_push, q_full, q_pop, q_empty;
    cmd_t              q_wdata, q_head;
    logic              flush_done;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;

    wts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata),
        .flush_done (flush_done),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata)
    );

    wts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    wts_ram #(
        .WIDTH (8),
        .DEPTH (RUN_DEPTH)
    ) u_run_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .flush_done (flush_done),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

FILE: dv/tb_whitespace_trim_stream.sv
// Self-checking testbench for whitespace_trim_stream: directed strings, then random text
// under every trim mode, several keep characters and varied handshake idling.
// Depends only on wts_pkg and the whitespace_trim_stream RTL.
`timescale 1ns / 1ps

module tb_whitespace_trim_stream;
    import wts_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 55;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;

    // Predictor state and the trimmed bytes still to come out
    logic [2:0] mode_r;
    logic [7:0] keep_r;
    logic       seen_word;
    logic       run_lost;
    logic [7:0] held_white[$];
    out_item_t  trimmed_q[$];

    int idle_pct       = 0;
    int stall_pct      = 0;
    int bytes_accepted = 0;
    int mismatch_count = 0;
    int hold_req       = 0;
    int hold_taken     = 0;
    int hold_left      = 0;

    whitespace_trim_stream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // Works out the results of one accepted byte and queues them.
    task automatic predict_trim(input in_item_t item);
        logic [7:0] step_bytes[$];
        logic       lead;
        logic       trail;
        logic       centre;
        logic       white;
        logic       drop_now;
        logic       keep_now;
        int         n_flush;
        out_item_t  r;
        lead    = mode_r[0];
        trail   = mode_r[1];
        centre  = mode_r[2];
        n_flush = 0;
        white   = (item.in_byte <= WHITE_MAX || item.in_byte >= TEXT_MIN)
                  && !(keep_r != 8'd0 && item.in_byte == keep_r);
        if (!white)
        begin
            // A word byte settles the held run: kept unless this mode drops it.
            if (held_white.size() > 0 && (seen_word ? !centre : !lead))
                step_bytes = held_white;
            held_white.delete();
            step_bytes.push_back(item.in_byte);
            seen_word = 1'b1;
        end
        else
        begin
            drop_now = seen_word ? (centre && trail) : lead;
            keep_now = seen_word ? (!centre && !trail) : (!lead && !trail);
            if (!drop_now)
            begin
                if (keep_now && held_white.size() == 0)
                    step_bytes.push_back(item.in_byte);
                else if (held_white.size() < RUN_DEPTH)
                    held_white.push_back(item.in_byte);
                else
                    run_lost = 1'b1;
            end
        end
        if (item.in_last && held_white.size() > 0)
        begin
            if (seen_word)
                n_flush = trail ? 0 : held_white.size();
            else if (!lead)
                n_flush = trail ? 1 : held_white.size();
            for (int i = 0; i < n_flush; i++)
                step_bytes.push_back(held_white[i]);
        end
        if (item.in_last && step_bytes.size() == 0)
        begin
            r = '{out_byte: 8'd0, has_byte: 1'b0, out_last: 1'b1, run_overflow: run_lost};
            trimmed_q.push_back(r);
        end
        foreach (step_bytes[i])
        begin
            r.out_byte     = step_bytes[i];
            r.has_byte     = 1'b1;
            r.out_last     = item.in_last && (i == step_bytes.size() - 1);
            r.run_overflow = run_lost;
            trimmed_q.push_back(r);
        end
        if (item.in_last)
        begin
            seen_word = 1'b0;
            run_lost  = 1'b0;
            held_white.delete();
        end
    endtask

    task automatic note_mismatch(input out_item_t want, input out_item_t got,
                                 input logic orphan);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            if (orphan)
                $display("%0t: result with nothing expected: byte=%0d has=%b last=%b ovf=%b",
                         $realtime, got.out_byte, got.has_byte, got.out_last,
                         got.run_overflow);
            else
                $display("%0t: mismatch: expected byte=%0d has=%b last=%b ovf=%b, got byte=%0d has=%b last=%b ovf=%b",
                         $realtime, want.out_byte, want.has_byte, want.out_last,
                         want.run_overflow, got.out_byte, got.has_byte, got.out_last,
                         got.run_overflow);
        end
    endtask

    // Each output transfer is checked against the oldest expected result.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (trimmed_q.size() == 0)
                note_mismatch('0, out_data, 1'b1);
            else
            begin
                want = trimmed_q.pop_front();
                if (want.out_byte !== out_data.out_byte || want.has_byte !== out_data.has_byte
                    || want.out_last !== out_data.out_last
                    || want.run_overflow !== out_data.run_overflow)
                    note_mismatch(want, out_data, 1'b0);
            end
        end
    end

    // Receiver stall: random, or held high for a long stretch on request.
    always @(negedge clk)
    begin
        if (hold_req != hold_taken)
        begin
            hold_taken = hold_req;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(input logic [7:0] value, input logic is_last);
        in_item_t item;
        item.in_byte = value;
        item.in_last = is_last;
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        predict_trim(item);
        bytes_accepted++;
    endtask

    // Stops offering input and lets every expected result come out.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (trimmed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == REG_TRIM_MODE)
            mode_r = value[2:0];
        else if (index == REG_KEEP_CHAR)
            keep_r = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] text_byte();
        if (keep_r != 8'd0 && $urandom_range(5) == 0)
            return keep_r;
        return 8'($urandom_range(33, 127));
    endfunction

    function automatic logic [7:0] white_byte();
        if ($urandom_range(1) == 1)
            return 8'($urandom_range(1, 32));
        return 8'($urandom_range(128, 255));
    endfunction

    // Alternating words and white runs; now and then a run longer than the store.
    task automatic send_text_string();
        logic [7:0] chars[$];
        int         segs;
        int         len;
        logic       in_word;
        segs    = $urandom_range(1, 6);
        in_word = 1'($urandom_range(1));
        for (int s = 0; s < segs; s++)
        begin
            if (!in_word && $urandom_range(7) == 0)
                len = $urandom_range(RUN_DEPTH + 1, RUN_DEPTH + 8);
            else
                len = $urandom_range(1, 4);
            repeat (len) chars.push_back(in_word ? text_byte() : white_byte());
            in_word = !in_word;
        end
        foreach (chars[i])
            send_item(chars[i], i == chars.size() - 1);
    endtask

    task automatic send_noise_string();
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom_range(1, 255)), i == len - 1);
    endtask

    task automatic test_reset_settings();
        send_item(8'd32, 1'b0);
        send_item("a", 1'b0);
        send_item(8'd32, 1'b0);
        send_item(8'd32, 1'b0);
        send_item("b", 1'b0);
        send_item(8'd1, 1'b1);
        send_item(8'd128, 1'b0);
        send_item(8'd255, 1'b1);
        send_item(8'd127, 1'b1);
        send_item(8'd33, 1'b1);
    endtask

    task automatic test_keep_char();
        wait_drained();
        write_reg(REG_KEEP_CHAR, 8'd32);
        send_item(8'd32, 1'b0);
        send_item("z", 1'b0);
        send_item(8'd9, 1'b0);
        send_item(8'd9, 1'b1);
        wait_drained();
        write_reg(REG_KEEP_CHAR, 8'd255);
        send_item(8'd255, 1'b0);
        send_item(8'd200, 1'b1);
    endtask

    // Trailing trim alone keeps the first byte of an all-white string.
    task automatic test_all_white_string();
        wait_drained();
        write_reg(REG_TRIM_MODE, 8'd2);
        write_reg(REG_KEEP_CHAR, 8'd0);
        send_item(8'd9, 1'b0);
        send_item(8'd200, 1'b0);
        send_item(8'd32, 1'b1);
    endtask

    // The held run is judged by the mode in force when the next word arrives.
    task automatic test_mode_change_mid_string();
        wait_drained();
        write_reg(REG_TRIM_MODE, 8'd3);
        send_item("q", 1'b0);
        send_item(8'd32, 1'b0);
        send_item(8'd32, 1'b0);
        wait_drained();
        write_reg(REG_TRIM_MODE, 8'd0);
        send_item("r", 1'b1);
        wait_drained();
        write_reg(REG_TRIM_MODE, 8'd4);
        send_item("w", 1'b0);
        send_item(8'd32, 1'b0);
        send_item(8'd32, 1'b1);
    endtask

    // Output held off for a long stretch while input keeps coming.
    task automatic test_output_backpressure();
        int start;
        wait_drained();
        write_reg(REG_TRIM_MODE, 8'd2);
        idle_pct  = 0;
        stall_pct = 0;
        hold_req++;
        start = bytes_accepted;
        while (bytes_accepted - start < 40)
            send_text_string();
        wait_drained();
    endtask

    task automatic test_random_settings();
        logic [2:0] mode_plan[8];
        logic [7:0] keep_plan[8];
        int         start;
        mode_plan = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6, 3'd3};
        keep_plan = '{8'd0, 8'd255, 8'd32, 8'd1, 8'd128, 8'd65, 8'd0, 8'd200};
        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            write_reg(REG_TRIM_MODE, {5'd0, mode_plan[p]});
            write_reg(REG_KEEP_CHAR, keep_plan[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            start = bytes_accepted;
            while (bytes_accepted - start < PHASE_ITEMS)
            begin
                if ($urandom_range(9) == 0)
                    send_noise_string();
                else
                    send_text_string();
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_TRIM_MODE;
        cfg_data  = 8'd0;
        in_valid  = 1'b0;
        in_data   = '0;
        mode_r    = TRIM_MODE_RESET;
        keep_r    = KEEP_CHAR_RESET;
        seen_word = 1'b0;
        run_lost  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_settings();
        test_keep_char();
        test_all_white_string();
        test_mode_change_mid_string();
        test_output_backpressure();
        test_random_settings();

        wait_drained();
        if (mismatch_count == 0 && trimmed_q.size() == 0)
            $display("PASS whitespace_trim_stream");
        else
            $display("FAIL whitespace_trim_stream");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #4000000;
        $display("FAIL whitespace_trim_stream");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/wts_pkg.sv
design/wts_ram.sv
design/wts_front.sv
design/wts_queue.sv
design/wts_back.sv
design/whitespace_trim_stream.sv
dv/tb_whitespace_trim_stream.sv
